@@ hw/rtl/bgac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgac_pkg
// Shared types, constants and helpers of the background autocrop bounds block.
// ----------------------------------------------------------------------------
package bgac_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int POS_W      = $clog2(MAX_DIM);
	localparam int DIM_W      = POS_W + 1;
	localparam int CHAN_W     = 8;
	localparam int WT_W       = 3;
	localparam int CONTRIB_W  = CHAN_W + WT_W;
	localparam int SQ_W       = 2 * CHAN_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int LIMIT_W    = 19;
	localparam int SUM_W      = 32;
	localparam int DIVISOR_W  = $clog2(4 * MAX_DIM) + 1;
	localparam int REM_W      = DIVISOR_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SQ     = 2'd2;

	// pixel action and result kind codes
	localparam logic ACT_SAMPLE      = 1'b0;
	localparam logic ACT_BOX         = 1'b1;
	localparam logic KIND_BACKGROUND = 1'b0;
	localparam logic KIND_BOX        = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic              result_kind;
		logic [CHAN_W-1:0] bg_red;
		logic [CHAN_W-1:0] bg_green;
		logic [CHAN_W-1:0] bg_blue;
		logic [DIM_W-1:0]  box_left;
		logic [POS_W-1:0]  box_right;
		logic [DIM_W-1:0]  box_top;
		logic [POS_W-1:0]  box_bottom;
		logic              crop_error;
	} result_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_SUMS,
		ST_DIV_RED,
		ST_DIV_GREEN,
		ST_DIV_BLUE,
		ST_EMIT_BG,
		ST_EMIT_BOX
	} state_t;

	typedef struct packed {
		logic  accept;
		logic  div_start;
		chan_t div_sel;
		logic  cap_red;
		logic  cap_green;
		logic  cap_blue;
		logic  emit_bg;
		logic  emit_box;
	} cmd_t;

	typedef struct packed {
		logic last_pos;
		logic end_seen;
		logic end_kind;
		logic div_done;
	} status_t;

	// Map out-of-range sizes: zero becomes one, above the maximum becomes the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > MAX_DIM_V) begin
			r = MAX_DIM_V;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bgac_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgac_divider
// Restoring divider, one quotient bit per cycle; keeps the low byte of the quotient.
// ----------------------------------------------------------------------------
module bgac_divider
	import bgac_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SUM_W-1:0]     dividend,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [CHAN_W-1:0]         quotient
);

	logic                  active_q;
	logic [STEP_W-1:0]     count_q;
	logic [REM_W-1:0]      rem_q;
	logic [SUM_W-1:0]      quo_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [REM_W:0]        trial;
	logic                  fits;
	logic [REM_W-1:0]      rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[SUM_W-1]};
		fits     = trial >= {1'b0, divisor_q};
		rem_next = fits ? REM_W'(trial - {1'b0, divisor_q}) : REM_W'(trial);
	end

	assign done     = active_q && (count_q == STEP_W'(DIV_STEPS - 1));
	assign quotient = {quo_q[CHAN_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			count_q  <= '0;
		end else if (active_q) begin
			count_q <= count_q + 1'b1;
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

	// shift dividend bits out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (active_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/bgac_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgac_datapath
// Configuration, position counters, pixel pipeline, border sums, box trackers
// and result register.
// ----------------------------------------------------------------------------
module bgac_datapath
	import bgac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire pixel_t                pixel,
	input  wire cmd_t                  cmd,
	output status_t                    status,
	output logic                       done,
	output result_t                    result
);

	// configuration
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DIM_W-1:0]   w_clamp;
	logic [DIM_W-1:0]   h_clamp;
	logic [POS_W-1:0]   w_last;
	logic [POS_W-1:0]   h_last;

	// position
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic             at_last_col;
	logic             at_last_row;
	logic [WT_W-1:0]  weight;

	// stage 1
	logic              v_s1;
	logic              act_s1;
	logic              last_s1;
	logic [CHAN_W-1:0] r_s1, g_s1, b_s1;
	logic [POS_W-1:0]  x_s1, y_s1;
	logic [WT_W-1:0]   wt_s1;

	// stage 2
	logic                 v_s2;
	logic                 act_s2;
	logic                 last_s2;
	logic [POS_W-1:0]     x_s2, y_s2;
	logic [CONTRIB_W-1:0] cr_s2, cg_s2, cb_s2;
	logic [SQ_W-1:0]      sqr_s2, sqg_s2, sqb_s2;

	// accumulators and trackers
	logic [SUM_W-1:0]  sum_red_q, sum_green_q, sum_blue_q;
	logic [DIM_W-1:0]  min_col_q, min_row_q;
	logic [POS_W-1:0]  max_col_q, max_row_q;
	logic [CHAN_W-1:0] bg_red_q, bg_green_q, bg_blue_q;
	logic [CHAN_W-1:0] q_red_q, q_green_q, q_blue_q;

	logic [CHAN_W-1:0]    ad_r, ad_g, ad_b;
	logic [DIST_W-1:0]    dist_sq;
	logic                 foreground;
	logic                 frame_clear;
	logic [SUM_W-1:0]     dividend;
	logic [DIVISOR_W-1:0] divisor;
	logic                 div_done;
	logic [CHAN_W-1:0]    quotient;
	logic [DIM_W-1:0]     left;
	logic [DIM_W-1:0]     top;
	result_t              result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			limit_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= DIM_W'(cfg_data);
				CFG_IMAGE_HEIGHT: height_q <= DIM_W'(cfg_data);
				CFG_LIMIT_SQ:     limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_clamp     = clamp_dim(width_q);
		h_clamp     = clamp_dim(height_q);
		w_last      = POS_W'(w_clamp - DIM_W'(1));
		h_last      = POS_W'(h_clamp - DIM_W'(1));
		at_last_col = col_q >= w_last;
		at_last_row = row_q >= h_last;
		weight      = WT_W'(row_q == '0) + WT_W'(row_q == h_last)
		            + WT_W'(col_q == '0) + WT_W'(col_q == w_last);
	end

	assign frame_clear = cmd.emit_bg || cmd.emit_box;

	// advance the raster position on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (!at_last_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= pixel.action;
		r_s1    <= pixel.red;
		g_s1    <= pixel.green;
		b_s1    <= pixel.blue;
		x_s1    <= col_q;
		y_s1    <= row_q;
		wt_s1   <= weight;
		last_s1 <= at_last_col && at_last_row;
	end

	always_comb begin
		ad_r = (r_s1 >= bg_red_q)   ? r_s1 - bg_red_q   : bg_red_q - r_s1;
		ad_g = (g_s1 >= bg_green_q) ? g_s1 - bg_green_q : bg_green_q - g_s1;
		ad_b = (b_s1 >= bg_blue_q)  ? b_s1 - bg_blue_q  : bg_blue_q - b_s1;
	end

	always_ff @(posedge clk) begin
		act_s2  <= act_s1;
		last_s2 <= last_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		cr_s2   <= CONTRIB_W'(wt_s1 * r_s1);
		cg_s2   <= CONTRIB_W'(wt_s1 * g_s1);
		cb_s2   <= CONTRIB_W'(wt_s1 * b_s1);
		sqr_s2  <= SQ_W'(ad_r * ad_r);
		sqg_s2  <= SQ_W'(ad_g * ad_g);
		sqb_s2  <= SQ_W'(ad_b * ad_b);
	end

	// a negative limit makes every pixel foreground
	always_comb begin
		dist_sq    = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);
		foreground = limit_q[LIMIT_W-1] || (dist_sq > limit_q[LIMIT_W-2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
			min_col_q   <= MAX_DIM_V;
			min_row_q   <= MAX_DIM_V;
			max_col_q   <= '0;
			max_row_q   <= '0;
		end else if (frame_clear) begin
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
			min_col_q   <= MAX_DIM_V;
			min_row_q   <= MAX_DIM_V;
			max_col_q   <= '0;
			max_row_q   <= '0;
		end else if (v_s2) begin
			if (act_s2 == ACT_SAMPLE) begin
				sum_red_q   <= sum_red_q + SUM_W'(cr_s2);
				sum_green_q <= sum_green_q + SUM_W'(cg_s2);
				sum_blue_q  <= sum_blue_q + SUM_W'(cb_s2);
			end else if (foreground) begin
				if ({1'b0, x_s2} < min_col_q) min_col_q <= {1'b0, x_s2};
				if (x_s2 > max_col_q)         max_col_q <= x_s2;
				if ({1'b0, y_s2} < min_row_q) min_row_q <= {1'b0, y_s2};
				if (y_s2 > max_row_q)         max_row_q <= y_s2;
			end
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			CH_RED:   dividend = sum_red_q;
			CH_GREEN: dividend = sum_green_q;
			CH_BLUE:  dividend = sum_blue_q;
			default:  dividend = sum_red_q;
		endcase
		divisor = DIVISOR_W'({w_clamp, 1'b0}) + DIVISOR_W'({h_clamp, 1'b0});
	end

	bgac_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_red)   q_red_q   <= quotient;
		if (cmd.cap_green) q_green_q <= quotient;
		if (cmd.cap_blue)  q_blue_q  <= quotient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_red_q   <= '0;
			bg_green_q <= '0;
			bg_blue_q  <= '0;
		end else if (cmd.emit_bg) begin
			bg_red_q   <= q_red_q;
			bg_green_q <= q_green_q;
			bg_blue_q  <= q_blue_q;
		end
	end

	always_comb begin
		left     = (min_col_q < w_clamp) ? min_col_q : w_clamp;
		top      = (min_row_q < h_clamp) ? min_row_q : h_clamp;
		result_d = '0;
		if (cmd.emit_bg) begin
			result_d.result_kind = KIND_BACKGROUND;
			result_d.bg_red      = q_red_q;
			result_d.bg_green    = q_green_q;
			result_d.bg_blue     = q_blue_q;
		end else begin
			result_d.result_kind = KIND_BOX;
			result_d.box_left    = left;
			result_d.box_right   = max_col_q;
			result_d.box_top     = top;
			result_d.box_bottom  = max_row_q;
			result_d.crop_error  = (left >= {1'b0, max_col_q}) || (top >= {1'b0, max_row_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= frame_clear;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_clear) begin
			result <= result_d;
		end
	end

	always_comb begin
		status.last_pos = at_last_col && at_last_row;
		status.end_seen = v_s2 && last_s2;
		status.end_kind = act_s2;
		status.div_done = div_done;
	end

endmodule
`default_nettype wire

@@ hw/rtl/bgac_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgac_ctrl
// Frame-end sequencer: runs the three divisions or emits the box result.
// ----------------------------------------------------------------------------
module bgac_ctrl
	import bgac_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy
);

	state_t state_q, state_d;
	logic   busy_q, busy_d;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.div_sel = CH_RED;
		cmd.accept = start && !busy_q;
		busy_d     = busy_q;
		// hold off new items from the last pixel of a frame until its result
		if (cmd.accept && status.last_pos) begin
			busy_d = 1'b1;
		end
		unique case (state_q)
			ST_RUN: begin
				if (status.end_seen) begin
					state_d = (status.end_kind == ACT_SAMPLE) ? ST_SUMS : ST_EMIT_BOX;
				end
			end
			ST_SUMS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = CH_RED;
				state_d       = ST_DIV_RED;
			end
			ST_DIV_RED: begin
				if (status.div_done) begin
					cmd.cap_red   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = CH_GREEN;
					state_d       = ST_DIV_GREEN;
				end
			end
			ST_DIV_GREEN: begin
				cmd.div_sel = CH_GREEN;
				if (status.div_done) begin
					cmd.cap_green = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = CH_BLUE;
					state_d       = ST_DIV_BLUE;
				end
			end
			ST_DIV_BLUE: begin
				cmd.div_sel = CH_BLUE;
				if (status.div_done) begin
					cmd.cap_blue = 1'b1;
					state_d      = ST_EMIT_BG;
				end
			end
			ST_EMIT_BG: begin
				cmd.emit_bg = 1'b1;
				busy_d      = 1'b0;
				state_d     = ST_RUN;
			end
			ST_EMIT_BOX: begin
				cmd.emit_box = 1'b1;
				busy_d       = 1'b0;
				state_d      = ST_RUN;
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/background_autocrop_bounds_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// background_autocrop_bounds_top
// Border background average and foreground bounding box over raster pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Program image_width, image_height and bg_distance_limit_sq through the
//   write port (cfg_we, cfg_index, cfg_data) between frames. Then feed a
//   sampling pass (action 0) and a box pass (action 1), one pixel item per
//   cycle in raster order: an item is taken when start is high and busy is
//   low. The raster position is counted inside the block.
//   Ordinary pixels are taken every cycle; busy stays low through a frame.
//   The last pixel of a frame raises busy until its result has been issued.
//   A box result appears on result with done high after the last pixel
//   has left the pixel pipe. A background result waits for three 32-step
//   divisions run one after the other on a single shared divider.
//   done is high for one cycle per result and the receiver cannot stall it:
//   it must take the result in that cycle. Busy drops at the same edge that
//   raises done, so the next frame may start while the result is shown.
//   Reset restores size 1 by 1, limit 0, a black background and position 0.
// ----------------------------------------------------------------------------
module background_autocrop_bounds_top
	import bgac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	input  wire pixel_t                pixel,
	output logic                       busy,
	output logic                       done,
	output result_t                    result
);

	// command and status between the sequencer and the datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: accepts items, tracks frame end, steps the divisions
	bgac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: counters, two-stage pixel pipe, sums, box trackers, divider
	bgac_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

@@ hw/rtl/bgac_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgac_checker
// Port-level checks of the autocrop bounds block, bound to the top level.
// ----------------------------------------------------------------------------
module bgac_checker
	import bgac_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	// results never come in back-to-back cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// busy only rises after an item was taken
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

	a_box_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.result_kind == KIND_BOX) |->
			(result.bg_red == '0 && result.bg_green == '0 && result.bg_blue == '0))
		else $error("box result carries background color");

	a_bg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.result_kind == KIND_BACKGROUND) |->
			(result.box_left == '0 && result.box_right == '0 && result.box_top == '0
			&& result.box_bottom == '0 && !result.crop_error))
		else $error("background result carries box fields");

	a_crop_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.result_kind == KIND_BOX) |->
			(result.crop_error == ((result.box_left >= {1'b0, result.box_right})
			|| (result.box_top >= {1'b0, result.box_bottom}))))
		else $error("crop error flag disagrees with box");

endmodule

bind background_autocrop_bounds_top bgac_checker u_checker (.*);
`default_nettype wire
